FILE: rtl/aspfp_pkg.sv
// ----------------------------------------------------------------------------
// aspfp_pkg
// Shared types and character codes for the ASCII setpoint frame parser.
// ----------------------------------------------------------------------------
package aspfp_pkg;

  localparam int unsigned FrameLen  = 6;
  localparam int unsigned NumValues = 5;
  localparam int unsigned ValueW    = 19;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [2:0]               byte_idx_t;
  typedef logic [7:0]               char_t;

  localparam char_t CharStart    = 8'h73;  // 's'
  localparam char_t CharMinus    = 8'h2D;  // '-'
  localparam char_t CharDigit0   = 8'h30;  // '0'
  localparam char_t CharRoll     = 8'h72;  // 'r'
  localparam char_t CharPitch    = 8'h70;  // 'p'
  localparam char_t CharThrottle = 8'h6F;  // 'o'
  localparam char_t CharYaw      = 8'h79;  // 'y'
  localparam char_t CharAltitude = 8'h67;  // 'g'

  localparam byte_idx_t LastIdx = byte_idx_t'(FrameLen - 1);

  typedef enum logic [2:0] {
    SLOT_ROLL     = 3'd0,
    SLOT_PITCH    = 3'd1,
    SLOT_THROTTLE = 3'd2,
    SLOT_YAW      = 3'd3,
    SLOT_ALTITUDE = 3'd4,
    SLOT_NONE     = 3'd7
  } slot_t;

  // Maps a selector letter to the holding register it addresses.
  function automatic slot_t slot_of(input char_t c);
    slot_t s;
    case (c)
      CharRoll:     s = SLOT_ROLL;
      CharPitch:    s = SLOT_PITCH;
      CharThrottle: s = SLOT_THROTTLE;
      CharYaw:      s = SLOT_YAW;
      CharAltitude: s = SLOT_ALTITUDE;
      default:      s = SLOT_NONE;
    endcase
    return s;
  endfunction

  // Unchecked digit: byte minus '0', range -48..207.
  function automatic value_t digit_of(input char_t c);
    return value_t'($signed({1'b0, c})) - value_t'($signed({1'b0, CharDigit0}));
  endfunction

endpackage

FILE: rtl/ascii_setpoint_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_setpoint_frame_parser_core
// Parses 's'-framed ASCII setpoint commands into five held setpoint registers.
// ----------------------------------------------------------------------------
// One byte enters per beat and produces one result beat: the five held
// setpoints after that byte and a flag that is high when the byte closed a
// frame. The held setpoint registers double as the
// output register, so a new byte is taken in every cycle in which the
// previous result is taken or no result is pending. The byte 's' always opens
// a new frame; the sixth byte after it closes the frame and updates the
// register picked by the first byte (r, p, o, y, g) with the signed four-digit
// value that follows the sign byte. Digits are not range checked.
module ascii_setpoint_frame_parser_core
  import aspfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [18:0]  roll_value,
  output logic signed [18:0]  pitch_value,
  output logic signed [18:0]  throttle_value,
  output logic signed [18:0]  yaw_value,
  output logic signed [18:0]  altitude_value,
  output logic                frame_done
);

  logic      frame_open;
  byte_idx_t byte_index;
  char_t     frame_bytes [FrameLen-1];
  value_t    held_values [NumValues];

  logic      accept;
  logic      is_start;
  logic      is_last;
  value_t    magnitude;
  value_t    frame_value;
  slot_t     slot;

  assign rx_ready = !out_valid || out_ready;
  assign accept   = rx_valid && rx_ready;
  assign is_start = (rx_byte == CharStart);
  assign is_last  = frame_open && !is_start && (byte_index == LastIdx);

  // The closing byte is the last digit and is used straight from the input.
  always_comb begin
    magnitude = digit_of(frame_bytes[2]) * value_t'(1000)
              + digit_of(frame_bytes[3]) * value_t'(100)
              + digit_of(frame_bytes[4]) * value_t'(10)
              + digit_of(rx_byte);
    frame_value = (frame_bytes[1] == CharMinus) ? -magnitude : magnitude;
    slot = slot_of(frame_bytes[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      byte_index <= '0;
      out_valid  <= 1'b0;
      frame_done <= 1'b0;
      for (int k = 0; k < NumValues; k++) begin
        held_values[k] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        out_valid  <= 1'b1;
        frame_done <= is_last;
        if (is_start) begin
          frame_open <= 1'b1;
          byte_index <= '0;
        end else if (frame_open) begin
          if (is_last) begin
            frame_open <= 1'b0;
            byte_index <= '0;
            if (slot != SLOT_NONE) begin
              held_values[slot] <= frame_value;
            end
          end else begin
            byte_index <= byte_index + byte_idx_t'(1);
          end
        end
      end
    end
  end

  // Frame byte store: payload only, the last byte is never stored.
  always_ff @(posedge clk) begin
    if (accept && frame_open && !is_start && !is_last) begin
      frame_bytes[byte_index] <= rx_byte;
    end
  end

  assign roll_value     = held_values[SLOT_ROLL];
  assign pitch_value    = held_values[SLOT_PITCH];
  assign throttle_value = held_values[SLOT_THROTTLE];
  assign yaw_value      = held_values[SLOT_YAW];
  assign altitude_value = held_values[SLOT_ALTITUDE];

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ASCII setpoint frame parser core.
// ----------------------------------------------------------------------------
// Bytes are pushed one beat at a time through the receive channel. A local
// copy of the frame state decodes the same stream, and every result beat is
// checked field by field against the oldest queued prediction. Directed
// frames cover the value extremes, the ignored byte, restart and an unknown
// selector; random traffic then runs under four idle and stall settings.
module tb_top;
  import aspfp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 175;

  typedef struct {
    value_t vals[NumValues];
    logic   done;
  } setpoint_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         rx_valid = 1'b0;
  logic         rx_ready;
  logic [7:0]   rx_byte = 8'h00;
  logic         out_valid;
  logic         out_ready = 1'b0;
  value_t       roll_value, pitch_value, throttle_value, yaw_value, altitude_value;
  logic         frame_done;

  ascii_setpoint_frame_parser_core dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_ready       (rx_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .roll_value     (roll_value),
    .pitch_value    (pitch_value),
    .throttle_value (throttle_value),
    .yaw_value      (yaw_value),
    .altitude_value (altitude_value),
    .frame_done     (frame_done)
  );

  // Local copy of the parser state.
  logic       frm_open;
  byte_idx_t  frm_idx;
  char_t      frm_bytes[FrameLen];
  value_t     held[NumValues];

  setpoint_beat_t pending_q[$];
  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_closed = 0;
  int frames_unmatched = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  char_t selector_set[NumValues] = '{CharRoll, CharPitch, CharThrottle, CharYaw, CharAltitude};
  string field_names[NumValues] = '{"roll", "pitch", "throttle", "yaw", "altitude"};

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("ascii_setpoint_frame_parser_core verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic int char_weight(input char_t c);
    return int'(c) - int'(CharDigit0);
  endfunction

  // Advances the local frame state by one accepted byte and queues the
  // result beat the block should produce for it.
  task automatic predict_setpoints(input char_t b);
    setpoint_beat_t nxt;
    logic closed;
    int sum;
    slot_t slot;
    closed = 1'b0;
    if (b == CharStart) begin
      frm_open = 1'b1;
      frm_idx = '0;
    end else if (frm_open) begin
      frm_bytes[frm_idx] = b;
      if (frm_idx == LastIdx) begin
        frm_idx = '0;
        frm_open = 1'b0;
        closed = 1'b1;
      end else begin
        frm_idx = frm_idx + byte_idx_t'(1);
      end
    end
    if (closed) begin
      sum = char_weight(frm_bytes[2]) * 1000 + char_weight(frm_bytes[3]) * 100
          + char_weight(frm_bytes[4]) * 10 + char_weight(frm_bytes[5]);
      if (frm_bytes[1] == CharMinus) sum = -sum;
      case (frm_bytes[0])
        CharRoll:     slot = SLOT_ROLL;
        CharPitch:    slot = SLOT_PITCH;
        CharThrottle: slot = SLOT_THROTTLE;
        CharYaw:      slot = SLOT_YAW;
        CharAltitude: slot = SLOT_ALTITUDE;
        default:      slot = SLOT_NONE;
      endcase
      if (slot != SLOT_NONE) held[slot] = value_t'(sum);
      else frames_unmatched++;
      frames_closed++;
    end
    foreach (held[k]) nxt.vals[k] = held[k];
    nxt.done = closed;
    pending_q.push_back(nxt);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result();
    setpoint_beat_t want;
    value_t got[NumValues];
    got = '{roll_value, pitch_value, throttle_value, yaw_value, altitude_value};
    if (pending_q.size() == 0) begin
      report_mismatch("unexpected result beat", 1, 0);
    end else begin
      want = pending_q.pop_front();
      foreach (got[k]) begin
        if (got[k] !== want.vals[k]) report_mismatch(field_names[k], got[k], want.vals[k]);
      end
      if (frame_done !== want.done) report_mismatch("frame_done", frame_done, want.done);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  // Sends one byte. Valid is held from the previous beat unless an idle
  // cycle is drawn, so back-to-back beats never toggle it within a step.
  task automatic send_byte(input char_t b);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!rx_ready);
    predict_setpoints(b);
    bytes_sent++;
  endtask

  task automatic send_seq(input char_t seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stops sending and waits until every queued result has come back.
  task automatic wait_all_results();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic char_t frame_content(input int pos);
    char_t c;
    if (pos == 0) begin
      if ($urandom_range(99) < 85) c = selector_set[$urandom_range(NumValues - 1)];
      else c = char_t'($urandom_range(255));
    end else if (pos == 1 && $urandom_range(1) == 0) begin
      c = CharMinus;
    end else if ($urandom_range(99) < 85) begin
      c = CharDigit0 + char_t'($urandom_range(9));
    end else begin
      c = char_t'($urandom_range(255));
    end
    return c;
  endfunction

  task automatic test_value_extremes();
    // The leading byte arrives with no frame open and must be ignored.
    send_seq('{8'hFF, CharStart, CharRoll, CharMinus, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               CharStart, CharPitch, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00});
    wait_all_results();
  endtask

  task automatic test_restart_and_unknown();
    // A start byte mid-frame drops the partial frame; the new one carries an
    // unknown selector, so it completes without touching any setpoint.
    send_seq('{CharStart, CharYaw, 8'h31, CharStart, 8'h51, CharMinus, 8'h39, 8'h30,
               8'h30, 8'h31});
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int sent;
    int kind;
    int len;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < ItemsPerPhase) begin
      kind = $urandom_range(99);
      if (kind < 88) begin
        // Mostly whole frames; some are cut short and then restarted.
        len = (kind < 75) ? FrameLen : $urandom_range(FrameLen - 1);
        send_byte(CharStart);
        for (int p = 0; p < len; p++) send_byte(frame_content(p));
        sent += len + 1;
      end else begin
        send_byte(char_t'($urandom_range(255)));
        sent++;
      end
    end
    wait_all_results();
  endtask

  initial begin
    frm_open = 1'b0;
    frm_idx = '0;
    foreach (frm_bytes[i]) frm_bytes[i] = '0;
    foreach (held[k]) held[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_value_extremes();
    test_restart_and_unknown();
    test_random_traffic(0, 0);
    test_random_traffic(65, 0);
    test_random_traffic(0, 65);
    test_random_traffic(29, 29);

    repeat (10) @(posedge clk);
    $display("covered %0d byte beats and %0d closed frames (%0d with unknown selector)",
             bytes_sent, frames_closed, frames_unmatched);
    $display("idle settings: none, sender 65%%, receiver 65%%, both 29%%");
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("ascii_setpoint_frame_parser_core verification clean");
    end else begin
      $display("ascii_setpoint_frame_parser_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/aspfp_pkg.sv
rtl/ascii_setpoint_frame_parser_core.sv
test/tb_top.sv
